[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl files
// both expect a clock named clock and a synchronous reset named reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BFSP_ASSERT_NOW(label, cond, consequent, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (consequent)) \
      else $error(msg);

// next-cycle implication
`define BFSP_ASSERT_NEXT(label, cond, consequent, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (consequent)) \
      else $error(msg);

`endif

[hw/rtl/bfsp_pkg.sv]
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared codes, widths and the interface types of the relaxation unit.
// ----------------------------------------------------------------------------
package bfsp_pkg;

   localparam int VERTEX_BITS      = 8;
   localparam int FIELD_COST_WIDTH = 16;
   localparam int DIST_BITS        = 32;
   localparam int VCOUNT_BITS      = 9;
   localparam int VCOUNT_RESET     = 256;

   localparam logic [1:0] OP_ADD_EDGE = 2'd0;
   localparam logic [1:0] OP_RUN      = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;
   localparam logic [1:0] OP_CLEAR    = 2'd3;

   localparam logic KIND_RUN  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic signed [DIST_BITS-1:0] DIST_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DIST_BITS-1:0] DIST_MIN = 32'sh8000_0000;
   localparam logic signed [DIST_BITS-1:0] DIST_UNREACHED = DIST_MAX;

   typedef struct packed {
      logic                        load;
      logic signed [DIST_BITS-1:0] from_dist;
      logic signed [DIST_BITS-1:0] cost;
      logic signed [DIST_BITS-1:0] to_dist;
      logic                        to_reached;
   } relax_req_type;

   typedef struct packed {
      logic                        improve;
      logic signed [DIST_BITS-1:0] new_dist;
   } relax_rsp_type;

endpackage

[hw/rtl/bfsp_ram.sv]
// ----------------------------------------------------------------------------
// bfsp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bfsp_relax_unit.sv]
// ----------------------------------------------------------------------------
// bfsp_relax_unit
// Shared relaxation unit: saturating distance plus cost, registered, then
// compared against the head vertex's current distance.
// ----------------------------------------------------------------------------
module bfsp_relax_unit (
   input  logic                   clock,
   input  bfsp_pkg::relax_req_type req,
   output bfsp_pkg::relax_rsp_type rsp
);

   import bfsp_pkg::*;

   logic signed [DIST_BITS:0]   sum_wide;
   logic signed [DIST_BITS-1:0] sum_sat;
   logic signed [DIST_BITS-1:0] sum_ff;

   always_comb begin
      sum_wide = {req.from_dist[DIST_BITS-1], req.from_dist}
               + {req.cost[DIST_BITS-1], req.cost};
      if (sum_wide[DIST_BITS] != sum_wide[DIST_BITS-1]) begin
         sum_sat = sum_wide[DIST_BITS] ? DIST_MIN : DIST_MAX;
      end else begin
         sum_sat = sum_wide[DIST_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req.load) begin
         sum_ff <= sum_sat;
      end
   end

   assign rsp.new_dist = sum_ff;
   assign rsp.improve  = !req.to_reached || (sum_ff < req.to_dist);

endmodule

[hw/rtl/bellman_ford_shortest_paths_core.sv]
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths_core
// Single-source shortest paths by repeated edge relaxation over a stored
// edge list, with a tail-ordered visit list built at the start of each run.
// ----------------------------------------------------------------------------
// add edge and clear: busy stays low, no result
// read: busy through ST_READ_WAIT, result on the ports as busy falls
// run: sort the stored edges by tail, then per pass fetch each listed edge and relax it
//   if its tail is reached; a source out of range answers next cycle, never busy
// edges take turns on the shared relax unit and distance RAM; results can not be stalled
// reset (synchronous) clears control state and reached marks, no RAM sweep
`include "assert_macros.svh"

module bellman_ford_shortest_paths_core #(
   parameter int MAX_VERTICES = 256,
   parameter int MAX_EDGES    = 1024,
   parameter int COST_BITS    = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // command channel
   input  logic                                      start,
   output logic                                      busy,
   input  logic [1:0]                                req_operation,
   input  logic [bfsp_pkg::VERTEX_BITS-1:0]          req_vertex_a,
   input  logic [bfsp_pkg::VERTEX_BITS-1:0]          req_vertex_b,
   input  logic signed [bfsp_pkg::FIELD_COST_WIDTH-1:0] req_edge_cost,
   // result channel
   output logic                                      rsp_strobe,
   output logic                                      rsp_result_kind,
   output logic signed [bfsp_pkg::DIST_BITS-1:0]     rsp_distance,
   output logic                                      rsp_reached,
   output logic                                      rsp_negative_cycle,
   output logic                                      rsp_edge_overflow,
   // configuration
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [bfsp_pkg::VCOUNT_BITS-1:0]          csr_vertex_count
);

   import bfsp_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int NW = $clog2(MAX_VERTICES + 1);
   localparam int CW = (NW > VCOUNT_BITS) ? NW : VCOUNT_BITS;
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int TW = $clog2(MAX_EDGES + 1);
   localparam int CB = (COST_BITS < FIELD_COST_WIDTH) ? COST_BITS : FIELD_COST_WIDTH;
   localparam int EDGE_BITS = 2 * VERTEX_BITS + CB;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_SORT,
      ST_FETCH,
      ST_ORDER_WAIT,
      ST_EDGE_WAIT,
      ST_FROM_WAIT,
      ST_TO_WAIT,
      ST_ADVANCE,
      ST_PASS_END
   } state_type;

   state_type                state_ff;
   logic [VCOUNT_BITS-1:0]   vcount_ff;
   logic [TW-1:0]            edge_total_ff;
   logic                     overflow_ff;
   logic                     cycle_ff;
   logic [NW-1:0]            pass_ff;
   logic [MAX_VERTICES-1:0]  reached_ff;
   logic                     changed_ff;
   logic [VW-1:0]            tail_ff;
   logic [TW-1:0]            scan_ff;
   logic                     pend_ff;
   logic [EW-1:0]            pend_idx_ff;
   logic [TW-1:0]            sort_k_ff;
   logic [EW-1:0]            vis_ff;
   logic [TW-1:0]            count_ff;
   logic [EDGE_BITS-1:0]     edge_ff;
   logic                     hit_ff;

   logic                        rsp_strobe_ff;
   logic                        rsp_kind_ff;
   logic signed [DIST_BITS-1:0] rsp_distance_ff;
   logic                        rsp_reached_ff;
   logic                        rsp_neg_ff;
   logic                        rsp_ovf_ff;

   // memory ports
   logic                 edge_wr_en;
   logic [EW-1:0]        edge_wr_addr;
   logic [EDGE_BITS-1:0] edge_wr_data;
   logic [EW-1:0]        edge_rd_addr;
   logic [EDGE_BITS-1:0] edge_rd_data;
   logic                 order_wr_en;
   logic [EW-1:0]        order_rd_data;
   logic                 dist_wr_en;
   logic [VW-1:0]        dist_wr_addr;
   logic [DIST_BITS-1:0] dist_wr_data;
   logic [VW-1:0]        dist_rd_addr;
   logic [DIST_BITS-1:0] dist_rd_data;

   relax_req_type relax_req;
   relax_rsp_type relax_rsp;

   logic [CW-1:0]          vc_cw;
   logic [CW-1:0]          n_cw;
   logic [VERTEX_BITS-1:0] rd_tail;
   logic [VERTEX_BITS-1:0] rd_head;
   logic [VERTEX_BITS-1:0] ff_head;
   logic                   sort_match;
   logic                   accept;
   logic                   a_in_range;

   // effective vertex count: 0 acts as 1, clipped to the store size
   always_comb begin
      vc_cw = CW'(vcount_ff);
      if (vcount_ff == '0) begin
         n_cw = CW'(1);
      end else if (vc_cw > CW'(MAX_VERTICES)) begin
         n_cw = CW'(MAX_VERTICES);
      end else begin
         n_cw = vc_cw;
      end
   end

   assign rd_tail    = edge_rd_data[EDGE_BITS-1 -: VERTEX_BITS];
   assign rd_head    = edge_rd_data[CB +: VERTEX_BITS];
   assign ff_head    = edge_ff[CB +: VERTEX_BITS];
   assign sort_match = (CW'(rd_tail) == CW'(tail_ff)) && (CW'(rd_head) < n_cw);
   assign accept     = start && (state_ff == ST_IDLE);
   assign a_in_range = CW'(req_vertex_a) < n_cw;

   always_comb begin
      edge_wr_en   = accept && (req_operation == OP_ADD_EDGE)
                     && (edge_total_ff < TW'(MAX_EDGES));
      edge_wr_addr = EW'(edge_total_ff);
      edge_wr_data = {req_vertex_a, req_vertex_b, req_edge_cost[CB-1:0]};

      edge_rd_addr = (state_ff == ST_ORDER_WAIT) ? order_rd_data : EW'(scan_ff);

      order_wr_en  = (state_ff == ST_SORT) && pend_ff && sort_match;

      dist_wr_en   = 1'b0;
      dist_wr_addr = VW'(req_vertex_a);
      dist_wr_data = '0;
      dist_rd_addr = VW'(req_vertex_a);
      case (state_ff)
         ST_IDLE: begin
            // source distance is set when the run is taken
            dist_wr_en = accept && (req_operation == OP_RUN) && a_in_range;
         end
         ST_EDGE_WAIT: begin
            dist_rd_addr = VW'(rd_tail);
         end
         ST_FROM_WAIT: begin
            dist_rd_addr = VW'(ff_head);
         end
         ST_TO_WAIT: begin
            dist_rd_addr = VW'(ff_head);
            dist_wr_en   = relax_rsp.improve;
            dist_wr_addr = VW'(ff_head);
            dist_wr_data = relax_rsp.new_dist;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      relax_req.load       = (state_ff == ST_FROM_WAIT);
      relax_req.from_dist  = dist_rd_data;
      relax_req.cost       = DIST_BITS'($signed(edge_ff[CB-1:0]));
      relax_req.to_dist    = dist_rd_data;
      relax_req.to_reached = reached_ff[VW'(ff_head)];
   end

   bfsp_ram #(.WIDTH(EDGE_BITS), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_wr_addr),
      .wr_data (edge_wr_data),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_rd_data)
   );

   bfsp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_order_ram (
      .clock   (clock),
      .wr_en   (order_wr_en),
      .wr_addr (EW'(sort_k_ff)),
      .wr_data (pend_idx_ff),
      .rd_addr (vis_ff),
      .rd_data (order_rd_data)
   );

   bfsp_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_VERTICES)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_wr_en),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_rd_data)
   );

   bfsp_relax_unit u_relax (
      .clock (clock),
      .req   (relax_req),
      .rsp   (relax_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vcount_ff     <= VCOUNT_BITS'(VCOUNT_RESET);
         edge_total_ff <= '0;
         overflow_ff   <= 1'b0;
         cycle_ff      <= 1'b0;
         pass_ff       <= '0;
         reached_ff    <= '0;
         changed_ff    <= 1'b0;
         pend_ff       <= 1'b0;
         sort_k_ff     <= '0;
         scan_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            vcount_ff <= csr_vertex_count;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_operation)
                     OP_ADD_EDGE: begin
                        if (edge_total_ff < TW'(MAX_EDGES)) begin
                           edge_total_ff <= edge_total_ff + TW'(1);
                        end else begin
                           overflow_ff <= 1'b1;
                        end
                     end
                     OP_RUN: begin
                        reached_ff <= '0;
                        cycle_ff   <= 1'b0;
                        pass_ff    <= '0;
                        if (a_in_range) begin
                           reached_ff[VW'(req_vertex_a)] <= 1'b1;
                           tail_ff   <= '0;
                           scan_ff   <= '0;
                           pend_ff   <= 1'b0;
                           sort_k_ff <= '0;
                           state_ff  <= ST_SORT;
                        end else begin
                           rsp_strobe_ff   <= 1'b1;
                           rsp_kind_ff     <= KIND_RUN;
                           rsp_distance_ff <= '0;
                           rsp_reached_ff  <= 1'b0;
                           rsp_neg_ff      <= 1'b0;
                           rsp_ovf_ff      <= overflow_ff;
                        end
                     end
                     OP_READ: begin
                        hit_ff   <= a_in_range && reached_ff[VW'(req_vertex_a)];
                        state_ff <= ST_READ_WAIT;
                     end
                     default: begin
                        edge_total_ff <= '0;
                     end
                  endcase
               end
            end
            ST_READ_WAIT: begin
               rsp_strobe_ff   <= 1'b1;
               rsp_kind_ff     <= KIND_READ;
               rsp_distance_ff <= hit_ff ? dist_rd_data : DIST_UNREACHED;
               rsp_reached_ff  <= hit_ff;
               rsp_neg_ff      <= cycle_ff;
               rsp_ovf_ff      <= overflow_ff;
               state_ff        <= ST_IDLE;
            end
            ST_SORT: begin
               // one tail vertex per sweep over the edge store, load order kept
               if (pend_ff && sort_match) begin
                  sort_k_ff <= sort_k_ff + TW'(1);
               end
               if (scan_ff < edge_total_ff) begin
                  pend_ff     <= 1'b1;
                  pend_idx_ff <= EW'(scan_ff);
                  scan_ff     <= scan_ff + TW'(1);
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     if ((CW'(tail_ff) + CW'(1)) == n_cw) begin
                        count_ff   <= sort_k_ff;
                        vis_ff     <= '0;
                        changed_ff <= 1'b0;
                        state_ff   <= (sort_k_ff == '0) ? ST_PASS_END : ST_FETCH;
                     end else begin
                        tail_ff <= tail_ff + VW'(1);
                        scan_ff <= '0;
                     end
                  end
               end
            end
            ST_FETCH: begin
               state_ff <= ST_ORDER_WAIT;
            end
            ST_ORDER_WAIT: begin
               state_ff <= ST_EDGE_WAIT;
            end
            ST_EDGE_WAIT: begin
               edge_ff  <= edge_rd_data;
               state_ff <= reached_ff[VW'(rd_tail)] ? ST_FROM_WAIT : ST_ADVANCE;
            end
            ST_FROM_WAIT: begin
               state_ff <= ST_TO_WAIT;
            end
            ST_TO_WAIT: begin
               if (relax_rsp.improve) begin
                  reached_ff[VW'(ff_head)] <= 1'b1;
                  changed_ff               <= 1'b1;
               end
               state_ff <= ST_ADVANCE;
            end
            ST_ADVANCE: begin
               if ((TW'(vis_ff) + TW'(1)) == count_ff) begin
                  state_ff <= ST_PASS_END;
               end else begin
                  vis_ff   <= vis_ff + EW'(1);
                  state_ff <= ST_FETCH;
               end
            end
            ST_PASS_END: begin
               if (!changed_ff) begin
                  rsp_strobe_ff   <= 1'b1;
                  rsp_kind_ff     <= KIND_RUN;
                  rsp_distance_ff <= '0;
                  rsp_reached_ff  <= 1'b0;
                  rsp_neg_ff      <= cycle_ff;
                  rsp_ovf_ff      <= overflow_ff;
                  state_ff        <= ST_IDLE;
               end else begin
                  pass_ff <= pass_ff + NW'(1);
                  if ((CW'(pass_ff) + CW'(1)) >= n_cw) begin
                     // still changing after n-1 passes: negative cycle
                     cycle_ff        <= 1'b1;
                     rsp_strobe_ff   <= 1'b1;
                     rsp_kind_ff     <= KIND_RUN;
                     rsp_distance_ff <= '0;
                     rsp_reached_ff  <= 1'b0;
                     rsp_neg_ff      <= 1'b1;
                     rsp_ovf_ff      <= overflow_ff;
                     state_ff        <= ST_IDLE;
                  end else begin
                     changed_ff <= 1'b0;
                     vis_ff     <= '0;
                     state_ff   <= ST_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = (state_ff == ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_distance       = rsp_distance_ff;
   assign rsp_reached        = rsp_reached_ff;
   assign rsp_negative_cycle = rsp_neg_ff;
   assign rsp_edge_overflow  = rsp_ovf_ff;

   `BFSP_ASSERT_NOW(a_strobe_idle, rsp_strobe, state_ff == ST_IDLE, "result while still busy")
   `BFSP_ASSERT_NOW(a_total_bound, 1'b1, edge_total_ff <= TW'(MAX_EDGES), "edge total past store size")
   `BFSP_ASSERT_NEXT(a_overflow_sticky, overflow_ff, overflow_ff, "overflow flag dropped")
   `BFSP_ASSERT_NOW(a_sort_bound, state_ff == ST_SORT, sort_k_ff <= edge_total_ff, "visit list longer than edge store")
   `BFSP_ASSERT_NEXT(a_read_busy, accept && (req_operation == OP_READ), busy && !rsp_strobe, "read transfer not held busy")

endmodule
